>>> src/band_level_peak_hold_meter_core_defines.svh
// Assertion macros for the band level peak hold meter.
// Included by band_level_peak_hold_meter_core; no other dependencies.
`ifndef BAND_LEVEL_PEAK_HOLD_METER_CORE_DEFINES_SVH
`define BAND_LEVEL_PEAK_HOLD_METER_CORE_DEFINES_SVH

`ifndef SYNTH
`define BLPHM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BLPHM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BLPHM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BLPHM_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> src/blphm_pkg.sv
// Package for the band level peak hold meter: sizes, register indexes,
// configuration and per-band state types. No dependencies.
package blphm_pkg;

    localparam int BAND_COUNT = 64;
    localparam int BAND_AW    = $clog2(BAND_COUNT);

    localparam logic [2:0] CFG_BAR_DECAY_ON      = 3'd0;
    localparam logic [2:0] CFG_BAR_FALL_STEP     = 3'd1;
    localparam logic [2:0] CFG_PEAK_DECAY_ON     = 3'd2;
    localparam logic [2:0] CFG_PEAK_FALL_STEP    = 3'd3;
    localparam logic [2:0] CFG_PEAK_HOLD_UPDATES = 3'd4;
    localparam logic [2:0] CFG_INVERTED          = 3'd5;

    typedef struct packed {
        logic        bar_decay_on;
        logic [14:0] bar_fall_step;
        logic        peak_decay_on;
        logic [14:0] peak_fall_step;
        logic [7:0]  peak_hold_updates;
        logic        inverted;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] bar;
        logic signed [15:0] peak;
        logic [7:0]         hold;
    } ent_t;

endpackage

>>> src/band_level_peak_hold_meter_core.sv
// Top level of the band level peak hold meter: config registers, band state
// memory with read-modify-write pipeline, output register. Uses blphm_pkg,
// blphm_update and band_level_peak_hold_meter_core_defines.svh.
//
// Usage:
//   Input channel s_valid/s_ready carries s_band_index and s_band_value.
//   Result channel m_valid/m_ready carries m_out_band, m_bar_level and
//   m_peak_level, one result per input transfer, in input order.
//   The synchronous read of the band state memory is issued at the transfer
//   edge; the update stage then computes the new state, writing it back and
//   loading the output register whenever the output register can advance.
//   Throughput is one item per cycle unless the receiver stalls; the single
//   memory read port and the one-entry update stage set that figure. The same
//   band in consecutive items is served by forwarding the freshly written state.
//   When the receiver stalls, the output register and the update stage hold
//   and s_ready drops once both are full; nothing is lost.
//   Reset (aresetn low, synchronous) empties the pipeline, restores the
//   register defaults and clears a valid bit per band, so every band reads
//   as zero at once; no clearing pass is needed.
//   Registers must be written via cfg_we/cfg_addr/cfg_wdata while idle; the block does not check.
`include "band_level_peak_hold_meter_core_defines.svh"

module band_level_peak_hold_meter_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [14:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [5:0]         s_band_index,
    input  logic signed [15:0] s_band_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_out_band,
    output logic signed [15:0] m_bar_level,
    output logic signed [15:0] m_peak_level
);

    blphm_pkg::cfg_t cfg_reg;

    blphm_pkg::ent_t mem [blphm_pkg::BAND_COUNT];
    logic [blphm_pkg::BAND_COUNT-1:0] vld_reg;

    logic                     p1_valid_reg;
    logic [5:0]               p1_band_reg;
    logic signed [15:0]       p1_value_reg;
    blphm_pkg::ent_t          rd_data_reg;
    logic                     rd_vld_reg;
    blphm_pkg::ent_t          fwd_data_reg;
    logic                     fwd_sel_reg;

    logic                     out_valid_reg;
    logic [5:0]               out_band_reg;
    logic signed [15:0]       out_bar_reg;
    logic signed [15:0]       out_peak_reg;

    logic                     s_xfer;
    logic                     advance;
    logic                     p1_in_range;
    logic                     mem_we;
    logic                     fwd_next;
    blphm_pkg::ent_t          old_ent;
    blphm_pkg::ent_t          new_ent;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bar_decay_on      <= 1'b0;
            cfg_reg.bar_fall_step     <= 15'd1;
            cfg_reg.peak_decay_on     <= 1'b0;
            cfg_reg.peak_fall_step    <= 15'd1;
            cfg_reg.peak_hold_updates <= 8'd10;
            cfg_reg.inverted          <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                blphm_pkg::CFG_BAR_DECAY_ON:      cfg_reg.bar_decay_on <= cfg_wdata[0];
                blphm_pkg::CFG_BAR_FALL_STEP:     cfg_reg.bar_fall_step <= cfg_wdata;
                blphm_pkg::CFG_PEAK_DECAY_ON:     cfg_reg.peak_decay_on <= cfg_wdata[0];
                blphm_pkg::CFG_PEAK_FALL_STEP:    cfg_reg.peak_fall_step <= cfg_wdata;
                blphm_pkg::CFG_PEAK_HOLD_UPDATES: cfg_reg.peak_hold_updates <= cfg_wdata[7:0];
                blphm_pkg::CFG_INVERTED:          cfg_reg.inverted <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign advance  = !out_valid_reg || m_ready;
    assign s_ready  = !p1_valid_reg || advance;
    assign s_xfer   = s_valid && s_ready;

    assign p1_in_range = {1'b0, p1_band_reg} < 7'(blphm_pkg::BAND_COUNT);
    assign mem_we      = p1_valid_reg && advance && p1_in_range;
    // next item hits the band being written this edge: memory read is stale
    assign fwd_next    = mem_we && (s_band_index == p1_band_reg);

    assign old_ent = fwd_sel_reg ? fwd_data_reg :
                     (rd_vld_reg ? rd_data_reg : '0);

    blphm_update u_update (
        .cfg     (cfg_reg),
        .old_ent (old_ent),
        .value   (p1_value_reg),
        .new_ent (new_ent)
    );

    // band state memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[p1_band_reg[blphm_pkg::BAND_AW-1:0]] <= new_ent;
        end
        if (s_xfer) begin
            rd_data_reg <= mem[s_band_index[blphm_pkg::BAND_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (mem_we) begin
            vld_reg[p1_band_reg[blphm_pkg::BAND_AW-1:0]] <= 1'b1;
        end
    end

    // update stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            fwd_sel_reg  <= 1'b0;
        end else if (s_xfer) begin
            p1_valid_reg <= 1'b1;
            fwd_sel_reg  <= fwd_next;
        end else if (advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            p1_band_reg  <= s_band_index;
            p1_value_reg <= s_band_value;
            rd_vld_reg   <= vld_reg[s_band_index[blphm_pkg::BAND_AW-1:0]];
            fwd_data_reg <= new_ent;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && p1_valid_reg) begin
            out_band_reg <= p1_band_reg;
            out_bar_reg  <= p1_in_range ? new_ent.bar : 16'sd0;
            out_peak_reg <= p1_in_range ? new_ent.peak : 16'sd0;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_band   = out_band_reg;
    assign m_bar_level  = out_bar_reg;
    assign m_peak_level = out_peak_reg;

    `BLPHM_ASSERT_IMP(a_no_accept_on_stall, aclk, aresetn, p1_valid_reg && !advance, !s_ready)
    `BLPHM_ASSERT_IMP(a_fwd_same_band, aclk, aresetn, p1_valid_reg && fwd_sel_reg, p1_band_reg == $past(p1_band_reg))
    `BLPHM_ASSERT_NXT(a_write_feeds_output, aclk, aresetn, mem_we, out_valid_reg)

endmodule

>>> src/blphm_update.sv
// Per-band update of bar, peak marker and hold counter for one value.
// Depends on blphm_pkg (cfg_t, ent_t).
module blphm_update (
    input  blphm_pkg::cfg_t     cfg,
    input  blphm_pkg::ent_t     old_ent,
    input  logic signed [15:0]  value,
    output blphm_pkg::ent_t     new_ent
);

    logic signed [17:0] val_x;
    logic signed [17:0] bar_x;
    logic signed [17:0] peak_x;
    logic signed [17:0] bstep_x;
    logic signed [17:0] pstep_x;
    logic signed [17:0] bar_dn;
    logic signed [17:0] bar_up;
    logic signed [17:0] peak_dn;
    logic [7:0]         hold_dec;

    assign val_x   = {{2{value[15]}}, value};
    assign bar_x   = {{2{old_ent.bar[15]}}, old_ent.bar};
    assign peak_x  = {{2{old_ent.peak[15]}}, old_ent.peak};
    assign bstep_x = {3'b000, cfg.bar_fall_step};
    assign pstep_x = {3'b000, cfg.peak_fall_step};
    assign bar_dn  = bar_x - bstep_x;
    assign bar_up  = bar_x + bstep_x;
    assign peak_dn = peak_x - pstep_x;
    assign hold_dec = (old_ent.hold == 8'd0) ? 8'd0 : old_ent.hold - 8'd1;

    always_comb begin
        // bar
        if (!cfg.bar_decay_on) begin
            new_ent.bar = value;
        end else if (cfg.inverted) begin
            if (val_x >= bar_up) begin
                new_ent.bar = (bar_up > 18'sd0) ? 16'sd0 : bar_up[15:0];
            end else begin
                new_ent.bar = value;
            end
        end else begin
            if (val_x <= bar_dn) begin
                new_ent.bar = bar_dn[17] ? 16'sd0 : bar_dn[15:0];
            end else begin
                new_ent.bar = value;
            end
        end

        // peak and hold; hold counts down before the compare
        if (!cfg.peak_decay_on) begin
            new_ent.peak = value;
            new_ent.hold = old_ent.hold;
        end else if (val_x > peak_x) begin
            new_ent.peak = value;
            new_ent.hold = cfg.peak_hold_updates;
        end else begin
            new_ent.hold = hold_dec;
            if (hold_dec == 8'd0) begin
                new_ent.peak = peak_dn[17] ? 16'sd0 : peak_dn[15:0];
            end else begin
                new_ent.peak = old_ent.peak;
            end
        end
    end

endmodule
